/* rtl/core/assert_macros.svh */
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

/* rtl/core/clsu_pkg.sv */
package clsu_pkg;
   localparam int MEM_ADDR_BITS = 16;
   localparam logic [1:0] OPER_EXEC = 2'd0;
   localparam logic [1:0] OPER_HWR = 2'd1;
   localparam logic [1:0] OPER_HRD = 2'd2;
   localparam logic [15:0] HIGH_PAGE = 16'hFF00;

   typedef struct packed {
      logic [7:0] a, f, b, c, d, e, h, l;
      logic [15:0] sp, pc;
   } regs_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] opcode;
      logic [15:0] immediate;
      logic [15:0] host_address;
      logic [7:0] host_data;
   } req_type;

   typedef struct packed {
      logic we;
      logic re;
      logic [MEM_ADDR_BITS-1:0] addr;
      logic [7:0] wdata;
   } mem_cmd_type;

   typedef enum logic [1:0] {ST_FIRST, ST_SECOND, ST_THIRD} phase_type;
endpackage

/* rtl/core/clsu_mem.sv */
module clsu_mem (
   input  logic clock,
   input  clsu_pkg::mem_cmd_type cmd,
   output logic [7:0] rdata
);
   import clsu_pkg::*;
   logic [7:0] mem [0:(1<<MEM_ADDR_BITS)-1];
   always_ff @(posedge clock) begin
      if (cmd.we) mem[cmd.addr] <= cmd.wdata;
      if (cmd.re) rdata <= mem[cmd.addr];
   end
endmodule

/* rtl/core/cpu_load_store_unit_core.sv */
// Load/store unit of an 8-bit CPU core.
// req_ channel: one request per instruction or host memory access.
// rsp_ channel: one response per request, in order, carrying the whole
// register file after the request, host read data and a bad-opcode flag.
// Every request runs through the single-port byte memory in phases:
// a first access (read or write) and a second access (second byte of
// PUSH, POP, LD (nn),SP); read data of the first access is used in the
// second phase. POP needs a third phase for its second read byte.
// A new request is accepted in the last phase of the one before it; the pace
// is set by that memory port and its registered read data.
// The response sits in an output register; a new request is accepted while
// it waits, and a request holds in its last phase only when its response
// would have nowhere to go (response register full and rsp_tready low).
// Reset clears the register file and the phase, busy and output-valid state;
// the memory has no reset and must be written before it is read.
module cpu_load_store_unit_core (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // operation[1:0], opcode[9:2], immediate[25:10], host_address[41:26], host_data[49:42]
   input  logic [55:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // a,f,b,c,d,e,h,l [63:0], sp[79:64], pc[95:80], read_data[103:96], bad_opcode[104]
   output logic [111:0] rsp_tdata
);
   import clsu_pkg::*;
   `include "assert_macros.svh"

   localparam int AW = MEM_ADDR_BITS;

   phase_type phase_ff, phase_in;
   req_type cur_ff, cur_in;
   regs_type r_ff, r_in;
   logic busy_ff, busy_in;
   logic ov_ff, ov_in;
   logic [111:0] od_ff, od_in;
   mem_cmd_type cmd;
   logic [7:0] rdata;
   logic [7:0] first_ff, first_in;
   logic bad, finish;

   clsu_mem u_mem (.clock(clock), .cmd(cmd), .rdata(rdata));

   req_type nq;
   assign nq = '{operation: req_tdata[1:0], opcode: req_tdata[9:2],
                 immediate: req_tdata[25:10], host_address: req_tdata[41:26],
                 host_data: req_tdata[49:42]};

   logic accept;

   logic [7:0] op, n;
   logic [15:0] hl, bc, de, imm, spm1, spm2, spp1;
   assign op = cur_ff.opcode;
   assign imm = cur_ff.immediate;
   assign n = imm[7:0];
   assign hl = {r_ff.h, r_ff.l};
   assign bc = {r_ff.b, r_ff.c};
   assign de = {r_ff.d, r_ff.e};
   assign spm1 = r_ff.sp - 16'd1;
   assign spm2 = r_ff.sp - 16'd2;
   assign spp1 = r_ff.sp + 16'd1;

   logic is_pop, last_phase;
   assign is_pop = cur_ff.operation == OPER_EXEC &&
                   (op == 8'hF1 || op == 8'hC1 || op == 8'hD1 || op == 8'hE1);
   assign last_phase = is_pop ? phase_ff == ST_THIRD : phase_ff == ST_SECOND;

   assign finish = busy_ff && last_phase && (!ov_ff || rsp_tready);
   assign req_tready = !busy_ff || finish;
   assign accept = req_tvalid && req_tready;

   function automatic logic [7:0] rget(regs_type r, logic [2:0] i, logic [7:0] m);
      unique case (i)
         3'd0: rget = r.b;
         3'd1: rget = r.c;
         3'd2: rget = r.d;
         3'd3: rget = r.e;
         3'd4: rget = r.h;
         3'd5: rget = r.l;
         3'd6: rget = m;
         default: rget = r.a;
      endcase
   endfunction

   function automatic regs_type rset(regs_type r, logic [2:0] i, logic [7:0] v);
      regs_type o;
      o = r;
      unique case (i)
         3'd0: o.b = v;
         3'd1: o.c = v;
         3'd2: o.d = v;
         3'd3: o.e = v;
         3'd4: o.h = v;
         3'd5: o.l = v;
         3'd6: o = r;
         default: o.a = v;
      endcase
      return o;
   endfunction

   logic is_ld_rr, is_ld_rn;
   assign is_ld_rr = op[7:6] == 2'b01 && op != 8'h76;
   assign is_ld_rn = (op & 8'hC7) == 8'h06;

   // memory port: first phase is the primary access, second the extra one
   always_comb begin
      cmd = '0;
      if (busy_ff && cur_ff.operation == OPER_EXEC && phase_ff == ST_FIRST) begin
         if (is_ld_rr) begin
            if (op[2:0] == 3'd6) begin
               cmd.re = 1'b1; cmd.addr = hl[AW-1:0];
            end else if (op[5:3] == 3'd6) begin
               cmd.we = 1'b1; cmd.addr = hl[AW-1:0]; cmd.wdata = rget(r_ff, op[2:0], 8'd0);
            end
         end else if (is_ld_rn) begin
            if (op[5:3] == 3'd6) begin
               cmd.we = 1'b1; cmd.addr = hl[AW-1:0]; cmd.wdata = n;
            end
         end else begin
            priority case (op)
               8'h02: begin cmd.we = 1'b1; cmd.addr = bc[AW-1:0]; cmd.wdata = r_ff.a; end
               8'h12: begin cmd.we = 1'b1; cmd.addr = de[AW-1:0]; cmd.wdata = r_ff.a; end
               8'h0A: begin cmd.re = 1'b1; cmd.addr = bc[AW-1:0]; end
               8'h1A: begin cmd.re = 1'b1; cmd.addr = de[AW-1:0]; end
               8'h22, 8'h32: begin cmd.we = 1'b1; cmd.addr = hl[AW-1:0]; cmd.wdata = r_ff.a; end
               8'h2A, 8'h3A: begin cmd.re = 1'b1; cmd.addr = hl[AW-1:0]; end
               8'hE0: begin
                  cmd.we = 1'b1; cmd.addr = AW'(HIGH_PAGE + {8'd0, n}); cmd.wdata = r_ff.a;
               end
               8'hF0: begin cmd.re = 1'b1; cmd.addr = AW'(HIGH_PAGE + {8'd0, n}); end
               8'hE2: begin
                  cmd.we = 1'b1; cmd.addr = AW'(HIGH_PAGE + {8'd0, r_ff.c}); cmd.wdata = r_ff.a;
               end
               8'hF2: begin cmd.re = 1'b1; cmd.addr = AW'(HIGH_PAGE + {8'd0, r_ff.c}); end
               8'hEA: begin cmd.we = 1'b1; cmd.addr = imm[AW-1:0]; cmd.wdata = r_ff.a; end
               8'hFA: begin cmd.re = 1'b1; cmd.addr = imm[AW-1:0]; end
               8'h08: begin cmd.we = 1'b1; cmd.addr = imm[AW-1:0]; cmd.wdata = r_ff.sp[7:0]; end
               8'hF5: begin cmd.we = 1'b1; cmd.addr = spm1[AW-1:0]; cmd.wdata = r_ff.a; end
               8'hC5: begin cmd.we = 1'b1; cmd.addr = spm1[AW-1:0]; cmd.wdata = r_ff.b; end
               8'hD5: begin cmd.we = 1'b1; cmd.addr = spm1[AW-1:0]; cmd.wdata = r_ff.d; end
               8'hE5: begin cmd.we = 1'b1; cmd.addr = spm1[AW-1:0]; cmd.wdata = r_ff.h; end
               8'hF1, 8'hC1, 8'hD1, 8'hE1: begin cmd.re = 1'b1; cmd.addr = r_ff.sp[AW-1:0]; end
               default: cmd = '0;
            endcase
         end
      end else if (busy_ff && cur_ff.operation == OPER_EXEC && phase_ff == ST_SECOND) begin
         priority case (op)
            8'h08: begin
               cmd.we = 1'b1; cmd.addr = AW'(imm + 16'd1); cmd.wdata = r_ff.sp[15:8];
            end
            8'hF5: begin cmd.we = 1'b1; cmd.addr = spm2[AW-1:0]; cmd.wdata = r_ff.f; end
            8'hC5: begin cmd.we = 1'b1; cmd.addr = spm2[AW-1:0]; cmd.wdata = r_ff.c; end
            8'hD5: begin cmd.we = 1'b1; cmd.addr = spm2[AW-1:0]; cmd.wdata = r_ff.e; end
            8'hE5: begin cmd.we = 1'b1; cmd.addr = spm2[AW-1:0]; cmd.wdata = r_ff.l; end
            8'hF1, 8'hC1, 8'hD1, 8'hE1: begin cmd.re = 1'b1; cmd.addr = spp1[AW-1:0]; end
            default: cmd = '0;
         endcase
      end else if (busy_ff && phase_ff == ST_FIRST) begin
         cmd.addr = cur_ff.host_address[AW-1:0];
         cmd.wdata = cur_ff.host_data;
         cmd.we = cur_ff.operation == OPER_HWR;
         cmd.re = cur_ff.operation == OPER_HRD;
      end
   end

   // first-phase read data lands in rdata during the second phase
   logic [15:0] ext, sum, chk;
   logic [1:0] len;
   assign ext = {{8{n[7]}}, n};
   assign sum = r_ff.sp + ext;
   assign chk = r_ff.sp ^ ext ^ sum;

   always_comb begin
      r_in = r_ff;
      bad = 1'b0;
      len = 2'd1;
      if (cur_ff.operation == OPER_EXEC) begin
         if (is_ld_rr) begin
            r_in = rset(r_ff, op[5:3], rget(r_ff, op[2:0], rdata));
         end else if (is_ld_rn) begin
            r_in = rset(r_ff, op[5:3], n);
            len = 2'd2;
         end else begin
            priority case (op)
               8'h02, 8'h12, 8'hE2: ;
               8'h0A, 8'h1A, 8'hF2: r_in.a = rdata;
               8'h22: {r_in.h, r_in.l} = hl + 16'd1;
               8'h32: {r_in.h, r_in.l} = hl - 16'd1;
               8'h2A: begin r_in.a = rdata; {r_in.h, r_in.l} = hl + 16'd1; end
               8'h3A: begin r_in.a = rdata; {r_in.h, r_in.l} = hl - 16'd1; end
               8'hE0: len = 2'd2;
               8'hF0: begin r_in.a = rdata; len = 2'd2; end
               8'hEA, 8'h08: len = 2'd3;
               8'hFA: begin r_in.a = rdata; len = 2'd3; end
               8'h01: begin {r_in.b, r_in.c} = imm; len = 2'd3; end
               8'h11: begin {r_in.d, r_in.e} = imm; len = 2'd3; end
               8'h21: begin {r_in.h, r_in.l} = imm; len = 2'd3; end
               8'h31: begin r_in.sp = imm; len = 2'd3; end
               8'hF9: r_in.sp = hl;
               8'hF8: begin
                  r_in.f = {2'b00, chk[4], chk[8], 4'd0};
                  {r_in.h, r_in.l} = sum;
                  len = 2'd2;
               end
               8'hF5, 8'hC5, 8'hD5, 8'hE5: r_in.sp = spm2;
               8'hF1: begin r_in.f = {first_ff[7:4], 4'd0}; r_in.a = rdata; r_in.sp = spm2 + 16'd4; end
               8'hC1: begin r_in.c = first_ff; r_in.b = rdata; r_in.sp = r_ff.sp + 16'd2; end
               8'hD1: begin r_in.e = first_ff; r_in.d = rdata; r_in.sp = r_ff.sp + 16'd2; end
               8'hE1: begin r_in.l = first_ff; r_in.h = rdata; r_in.sp = r_ff.sp + 16'd2; end
               default: bad = 1'b1;
            endcase
         end
         r_in.pc = r_ff.pc + {14'd0, len};
      end
   end

   logic [7:0] rd_out;
   assign rd_out = cur_ff.operation == OPER_HRD ? rdata : 8'd0;

   always_comb begin
      phase_in = phase_ff;
      busy_in = busy_ff;
      cur_in = cur_ff;
      first_in = first_ff;
      ov_in = ov_ff && !rsp_tready;
      od_in = od_ff;
      if (busy_ff && phase_ff == ST_FIRST) begin
         phase_in = ST_SECOND;
      end
      if (busy_ff && phase_ff == ST_SECOND && is_pop) begin
         phase_in = ST_THIRD;
         first_in = rdata;
      end
      if (finish) begin
         busy_in = 1'b0;
         ov_in = 1'b1;
         od_in = {7'd0, bad, rd_out, r_in.pc, r_in.sp, r_in.l, r_in.h, r_in.e, r_in.d,
                  r_in.c, r_in.b, r_in.f, r_in.a};
      end
      if (accept) begin
         busy_in = 1'b1;
         phase_in = ST_FIRST;
         cur_in = nq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ST_FIRST;
         busy_ff <= 1'b0;
         ov_ff <= 1'b0;
         r_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         busy_ff <= busy_in;
         ov_ff <= ov_in;
         if (finish) r_ff <= r_in;
      end
      cur_ff <= cur_in;
      od_ff <= od_in;
      first_ff <= first_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = od_ff;

   `ASSERT_IMPL(a_second_after_first, clock, reset,
      (busy_ff && phase_ff == ST_FIRST) |=> (busy_ff && phase_ff == ST_SECOND))
   `ASSERT_NEVER(a_no_accept_mid, clock, reset,
      accept && busy_ff && phase_ff == ST_FIRST)
   `ASSERT_IMPL(a_finish_sets_out, clock, reset, finish |=> rsp_tvalid)
   `ASSERT_NEVER(a_third_only_pop, clock, reset,
      busy_ff && phase_ff == ST_THIRD && !is_pop)
endmodule

/* tb/cpu_load_store_unit_core_tb.sv */
`timescale 1ns / 1ps
module cpu_load_store_unit_core_tb;
   import clsu_pkg::*;

   typedef struct packed {
      logic [7:0] a, f, b, c, d, e, h, l;
      logic [15:0] sp, pc;
      logic [7:0] read_data;
      logic bad_opcode;
   } state_snap_type;

   typedef struct {
      logic [1:0] operation;
      logic [7:0] opcode;
      logic [15:0] immediate;
      logic [15:0] host_address;
      logic [7:0] host_data;
      logic check_fixed;
      state_snap_type fixed;
   } stim_row_type;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 1700;

   logic clock, reset;
   logic req_tvalid, req_tready;
   logic [55:0] req_tdata;
   logic rsp_tvalid, rsp_tready;
   logic [111:0] rsp_tdata;

   cpu_load_store_unit_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // predictor state
   logic [7:0] cpu_a, cpu_f, cpu_b, cpu_c, cpu_d, cpu_e, cpu_h, cpu_l;
   logic [15:0] cpu_sp, cpu_pc;
   logic [7:0] cpu_mem [logic [15:0]];
   state_snap_type expected_regs [$];
   logic fixed_flag [$];
   state_snap_type fixed_value [$];

   int errors = 0;
   int idle_cycles = 0;
   int drain_wait;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic logic [7:0] mem_get(logic [15:0] addr);
      return cpu_mem.exists(addr) ? cpu_mem[addr] : 8'h00;
   endfunction

   function automatic logic [7:0] reg_by_index(logic [2:0] idx);
      case (idx)
         3'd0: return cpu_b;
         3'd1: return cpu_c;
         3'd2: return cpu_d;
         3'd3: return cpu_e;
         3'd4: return cpu_h;
         3'd5: return cpu_l;
         3'd6: return mem_get({cpu_h, cpu_l});
         default: return cpu_a;
      endcase
   endfunction

   task automatic reg_write(logic [2:0] idx, logic [7:0] v);
      case (idx)
         3'd0: cpu_b = v;
         3'd1: cpu_c = v;
         3'd2: cpu_d = v;
         3'd3: cpu_e = v;
         3'd4: cpu_h = v;
         3'd5: cpu_l = v;
         3'd6: cpu_mem[{cpu_h, cpu_l}] = v;
         default: cpu_a = v;
      endcase
   endtask

   task automatic push_byte(logic [7:0] v);
      cpu_sp = cpu_sp - 16'd1;
      cpu_mem[cpu_sp] = v;
   endtask

   task automatic pop_byte(output logic [7:0] v);
      v = mem_get(cpu_sp);
      cpu_sp = cpu_sp + 16'd1;
   endtask

   task automatic run_instruction(input logic [7:0] op, input logic [15:0] imm,
                                  output int len);
      logic [7:0] n, t;
      logic [15:0] hl, ext, sum, chk;
      n = imm[7:0];
      hl = {cpu_h, cpu_l};
      len = 1;
      if (op >= 8'h40 && op <= 8'h7F) begin
         if (op == 8'h76) len = 0;
         else reg_write(op[5:3], reg_by_index(op[2:0]));
      end else if ((op & 8'hC7) == 8'h06) begin
         reg_write(op[5:3], n);
         len = 2;
      end else begin
         case (op)
            8'h02: cpu_mem[{cpu_b, cpu_c}] = cpu_a;
            8'h12: cpu_mem[{cpu_d, cpu_e}] = cpu_a;
            8'h0A: cpu_a = mem_get({cpu_b, cpu_c});
            8'h1A: cpu_a = mem_get({cpu_d, cpu_e});
            8'h22: begin cpu_mem[hl] = cpu_a; {cpu_h, cpu_l} = hl + 16'd1; end
            8'h2A: begin cpu_a = mem_get(hl); {cpu_h, cpu_l} = hl + 16'd1; end
            8'h32: begin cpu_mem[hl] = cpu_a; {cpu_h, cpu_l} = hl - 16'd1; end
            8'h3A: begin cpu_a = mem_get(hl); {cpu_h, cpu_l} = hl - 16'd1; end
            8'hE0: begin cpu_mem[HIGH_PAGE | n] = cpu_a; len = 2; end
            8'hF0: begin cpu_a = mem_get(HIGH_PAGE | n); len = 2; end
            8'hE2: cpu_mem[HIGH_PAGE | cpu_c] = cpu_a;
            8'hF2: cpu_a = mem_get(HIGH_PAGE | cpu_c);
            8'hEA: begin cpu_mem[imm] = cpu_a; len = 3; end
            8'hFA: begin cpu_a = mem_get(imm); len = 3; end
            8'h01: begin {cpu_b, cpu_c} = imm; len = 3; end
            8'h11: begin {cpu_d, cpu_e} = imm; len = 3; end
            8'h21: begin {cpu_h, cpu_l} = imm; len = 3; end
            8'h31: begin cpu_sp = imm; len = 3; end
            8'hF9: cpu_sp = hl;
            8'hF8: begin
               ext = {{8{n[7]}}, n};
               sum = cpu_sp + ext;
               chk = cpu_sp ^ ext ^ sum;
               cpu_f = {2'b00, chk[4], chk[8], 4'h0};
               {cpu_h, cpu_l} = sum;
               len = 2;
            end
            8'h08: begin
               cpu_mem[imm] = cpu_sp[7:0];
               cpu_mem[imm + 16'd1] = cpu_sp[15:8];
               len = 3;
            end
            8'hF5: begin push_byte(cpu_a); push_byte(cpu_f); end
            8'hC5: begin push_byte(cpu_b); push_byte(cpu_c); end
            8'hD5: begin push_byte(cpu_d); push_byte(cpu_e); end
            8'hE5: begin push_byte(cpu_h); push_byte(cpu_l); end
            8'hF1: begin pop_byte(t); cpu_f = t & 8'hF0; pop_byte(cpu_a); end
            8'hC1: begin pop_byte(cpu_c); pop_byte(cpu_b); end
            8'hD1: begin pop_byte(cpu_e); pop_byte(cpu_d); end
            8'hE1: begin pop_byte(cpu_l); pop_byte(cpu_h); end
            default: len = 0;
         endcase
      end
   endtask

   task automatic predict_request(input stim_row_type r);
      state_snap_type s;
      int len;
      logic [7:0] rd;
      logic bad;
      rd = 8'h00;
      bad = 1'b0;
      if (r.operation == OPER_EXEC) begin
         run_instruction(r.opcode, r.immediate, len);
         if (len == 0) begin
            bad = 1'b1;
            len = 1;
         end
         cpu_pc = cpu_pc + 16'(len);
      end else if (r.operation == OPER_HWR) begin
         cpu_mem[r.host_address] = r.host_data;
      end else if (r.operation == OPER_HRD) begin
         rd = mem_get(r.host_address);
      end
      s = '{cpu_a, cpu_f, cpu_b, cpu_c, cpu_d, cpu_e, cpu_h, cpu_l, cpu_sp, cpu_pc,
            rd, bad};
      expected_regs.push_back(s);
      fixed_flag.push_back(r.check_fixed);
      fixed_value.push_back(r.fixed);
   endtask

   // opcodes that read memory at an address that may never have been written
   function automatic logic reads_unknown(logic [7:0] op, logic [15:0] imm);
      logic [15:0] hl;
      hl = {cpu_h, cpu_l};
      if (op >= 8'h40 && op <= 8'h7F && op != 8'h76 && op[2:0] == 3'd6)
         return !cpu_mem.exists(hl);
      case (op)
         8'h0A: return !cpu_mem.exists({cpu_b, cpu_c});
         8'h1A: return !cpu_mem.exists({cpu_d, cpu_e});
         8'h2A, 8'h3A: return !cpu_mem.exists(hl);
         8'hF0: return !cpu_mem.exists(HIGH_PAGE | imm[7:0]);
         8'hF2: return !cpu_mem.exists(HIGH_PAGE | cpu_c);
         8'hFA: return !cpu_mem.exists(imm);
         8'hF1, 8'hC1, 8'hD1, 8'hE1:
            return !cpu_mem.exists(cpu_sp) || !cpu_mem.exists(cpu_sp + 16'd1);
         default: return 1'b0;
      endcase
   endfunction

   task automatic send_request(input stim_row_type r);
      req_tdata <= {6'd0, r.host_data, r.host_address, r.immediate, r.opcode,
                    r.operation};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_request(r);
      @(negedge clock);
   endtask

   task automatic maybe_gap();
      int g;
      if ($urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         g = $urandom_range(1, 6);
         repeat (g) @(negedge clock);
      end
   endtask

   // receiver and checker
   always @(posedge clock) begin
      state_snap_type got, want, fx;
      logic use_fixed;
      if (!reset) begin
         if (req_tvalid && req_tready || rsp_tvalid && rsp_tready) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            got.a = rsp_tdata[7:0];
            got.f = rsp_tdata[15:8];
            got.b = rsp_tdata[23:16];
            got.c = rsp_tdata[31:24];
            got.d = rsp_tdata[39:32];
            got.e = rsp_tdata[47:40];
            got.h = rsp_tdata[55:48];
            got.l = rsp_tdata[63:56];
            got.sp = rsp_tdata[79:64];
            got.pc = rsp_tdata[95:80];
            got.read_data = rsp_tdata[103:96];
            got.bad_opcode = rsp_tdata[104];
            if (expected_regs.size() == 0) begin
               $error("response with nothing expected: %h", got);
               errors++;
            end else begin
               want = expected_regs.pop_front();
               use_fixed = fixed_flag.pop_front();
               fx = fixed_value.pop_front();
               if (use_fixed && fx != want) begin
                  $error("table value differs from prediction: %h vs %h", fx, want);
                  errors++;
               end
               if (got.a != want.a) begin $error("a exp %h got %h", want.a, got.a); errors++; end
               if (got.f != want.f) begin $error("f exp %h got %h", want.f, got.f); errors++; end
               if (got.b != want.b) begin $error("b exp %h got %h", want.b, got.b); errors++; end
               if (got.c != want.c) begin $error("c exp %h got %h", want.c, got.c); errors++; end
               if (got.d != want.d) begin $error("d exp %h got %h", want.d, got.d); errors++; end
               if (got.e != want.e) begin $error("e exp %h got %h", want.e, got.e); errors++; end
               if (got.h != want.h) begin $error("h exp %h got %h", want.h, got.h); errors++; end
               if (got.l != want.l) begin $error("l exp %h got %h", want.l, got.l); errors++; end
               if (got.sp != want.sp) begin
                  $error("sp exp %h got %h", want.sp, got.sp); errors++;
               end
               if (got.pc != want.pc) begin
                  $error("pc exp %h got %h", want.pc, got.pc); errors++;
               end
               if (got.read_data != want.read_data) begin
                  $error("read_data exp %h got %h", want.read_data, got.read_data); errors++;
               end
               if (got.bad_opcode != want.bad_opcode) begin
                  $error("bad_opcode exp %h got %h", want.bad_opcode, got.bad_opcode);
                  errors++;
               end
            end
         end
      end
   end

   // receiver stall pattern: alternate ready-always stretches and random stalls
   always @(negedge clock) begin
      int ph;
      ph = int'(($time / 400) % 3);
      if (reset || ph == 0) rsp_tready <= 1'b1;
      else if (ph == 1) rsp_tready <= ($urandom_range(0, 3) != 0);
      else rsp_tready <= ($urandom_range(0, 1) == 0);
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic stim_row_type mk(logic [1:0] oper, logic [7:0] op, logic [15:0] imm,
                                       logic [15:0] ha, logic [7:0] hd);
      stim_row_type r;
      r.operation = oper; r.opcode = op; r.immediate = imm;
      r.host_address = ha; r.host_data = hd;
      r.check_fixed = 1'b0; r.fixed = '0;
      return r;
   endfunction

   function automatic stim_row_type mkx(logic [1:0] oper, logic [7:0] op, logic [15:0] imm,
                                        logic [15:0] ha, logic [7:0] hd, state_snap_type s);
      stim_row_type r;
      r = mk(oper, op, imm, ha, hd);
      r.check_fixed = 1'b1;
      r.fixed = s;
      return r;
   endfunction

   localparam logic [7:0] OP_LD_HL_NN = 8'h21, OP_LD_SP_NN = 8'h31, OP_LDHL = 8'hF8;
   localparam logic [7:0] OP_HALT = 8'h76, OP_POP_AF = 8'hF1, OP_PUSH_BC = 8'hC5;
   localparam logic [7:0] OP_LD_NN_SP = 8'h08, OP_LD_A_NN = 8'hFA, OP_LD_A_N = 8'h3E;
   localparam logic [7:0] OP_LDI_HL_A = 8'h22, OP_LDD_A_HL = 8'h3A, OP_POP_BC = 8'hC1;
   localparam logic [7:0] OP_LDH_N_A = 8'hE0, OP_LDH_A_N = 8'hF0, OP_LD_C_A = 8'hE2;
   localparam logic [7:0] OP_LD_SP_HL = 8'hF9, OP_UNUSED = 8'hD3, OP_LD_BC_NN = 8'h01;
   localparam logic [7:0] OP_PUSH_AF = 8'hF5, OP_LD_A_C = 8'hF2;
   localparam logic [1:0] OPER_NONE = 2'd3;

   initial begin
      stim_row_type table_rows [$];
      stim_row_type r;
      logic [7:0] op;
      int sent, roll;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      {cpu_a, cpu_f, cpu_b, cpu_c, cpu_d, cpu_e, cpu_h, cpu_l} = '0;
      cpu_sp = '0;
      cpu_pc = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      table_rows.push_back(mkx(OPER_HWR, 8'h00, 16'h0000, 16'hFFFF, 8'hFF,
                               '{8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0,
                                 16'h0, 16'h0, 8'h0, 1'b0}));
      table_rows.push_back(mkx(OPER_HRD, 8'hFF, 16'hFFFF, 16'hFFFF, 8'h00,
                               '{8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0,
                                 16'h0, 16'h0, 8'hFF, 1'b0}));
      table_rows.push_back(mkx(OPER_EXEC, OP_HALT, 16'h0000, 16'h0, 8'h0,
                               '{8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0,
                                 16'h0, 16'h1, 8'h0, 1'b1}));
      table_rows.push_back(mkx(OPER_NONE, OP_LD_A_N, 16'hFFFF, 16'hFFFF, 8'hFF,
                               '{8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0,
                                 16'h0, 16'h1, 8'h0, 1'b0}));
      table_rows.push_back(mk(OPER_EXEC, OP_LD_SP_NN, 16'h0000, 16'h0, 8'h0));
      table_rows.push_back(mk(OPER_EXEC, OP_LD_A_N, 16'h00FF, 16'h0, 8'h0));
      table_rows.push_back(mk(OPER_EXEC, OP_PUSH_AF, 16'h0, 16'h0, 8'h0));
      table_rows.push_back(mk(OPER_EXEC, OP_LDHL, 16'h00FF, 16'h0, 8'h0));
      table_rows.push_back(mk(OPER_EXEC, OP_LDHL, 16'h0001, 16'h0, 8'h0));
      table_rows.push_back(mk(OPER_EXEC, OP_LD_BC_NN, 16'hFFFF, 16'h0, 8'h0));
      table_rows.push_back(mk(OPER_EXEC, OP_PUSH_BC, 16'h0, 16'h0, 8'h0));
      table_rows.push_back(mk(OPER_EXEC, OP_POP_AF, 16'h0, 16'h0, 8'h0));
      table_rows.push_back(mk(OPER_EXEC, OP_PUSH_AF, 16'h0, 16'h0, 8'h0));
      table_rows.push_back(mk(OPER_EXEC, OP_POP_BC, 16'h0, 16'h0, 8'h0));
      table_rows.push_back(mk(OPER_EXEC, OP_LD_NN_SP, 16'hFFFF, 16'h0, 8'h0));
      table_rows.push_back(mk(OPER_EXEC, OP_LD_A_NN, 16'h0000, 16'h0, 8'h0));
      table_rows.push_back(mk(OPER_EXEC, OP_LD_HL_NN, 16'hFFFF, 16'h0, 8'h0));
      table_rows.push_back(mk(OPER_EXEC, OP_LDI_HL_A, 16'h0, 16'h0, 8'h0));
      table_rows.push_back(mk(OPER_EXEC, OP_LDD_A_HL, 16'h0, 16'h0, 8'h0));
      table_rows.push_back(mk(OPER_EXEC, OP_LDH_N_A, 16'h00FF, 16'h0, 8'h0));
      table_rows.push_back(mk(OPER_EXEC, OP_LDH_A_N, 16'h00FF, 16'h0, 8'h0));
      table_rows.push_back(mk(OPER_EXEC, OP_LD_C_A, 16'h0, 16'h0, 8'h0));
      table_rows.push_back(mk(OPER_EXEC, OP_LD_A_C, 16'h0, 16'h0, 8'h0));
      table_rows.push_back(mk(OPER_EXEC, OP_LD_SP_HL, 16'h0, 16'h0, 8'h0));
      table_rows.push_back(mk(OPER_EXEC, OP_UNUSED, 16'hFFFF, 16'h0, 8'h0));

      foreach (table_rows[i]) begin
         send_request(table_rows[i]);
         maybe_gap();
      end

      // random part: host accesses, no-op operation codes and random opcodes, whose reads hit written bytes
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 15) begin
            r = mk(OPER_HWR, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
            if ($urandom_range(0, 3) == 0) r.host_address = HIGH_PAGE | 16'($urandom_range(0, 255));
         end else if (roll < 25) begin
            r = mk(OPER_HRD, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
            if (!cpu_mem.exists(r.host_address)) r.operation = OPER_HWR;
         end else if (roll < 27) begin
            r = mk(OPER_NONE, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
         end else begin
            op = 8'($urandom);
            r = mk(OPER_EXEC, op, 16'($urandom), 16'($urandom), 8'($urandom));
            if (reads_unknown(op, r.immediate)) begin
               // seed the needed bytes by a store of the same address instead
               r.operation = OPER_HWR;
               case (op)
                  8'h0A: r.host_address = {cpu_b, cpu_c};
                  8'h1A: r.host_address = {cpu_d, cpu_e};
                  8'hF0: r.host_address = HIGH_PAGE | r.immediate[7:0];
                  8'hF2: r.host_address = HIGH_PAGE | cpu_c;
                  8'hFA: r.host_address = r.immediate;
                  8'hF1, 8'hC1, 8'hD1, 8'hE1:
                     r.host_address = cpu_mem.exists(cpu_sp) ? cpu_sp + 16'd1 : cpu_sp;
                  default: r.host_address = {cpu_h, cpu_l};
               endcase
            end
         end
         send_request(r);
         sent++;
         maybe_gap();
      end
      req_tvalid <= 1'b0;

      while (expected_regs.size() != 0) @(posedge clock);
      drain_wait = 0;
      while (drain_wait < 20) begin
         @(posedge clock);
         drain_wait++;
      end
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule
